// ===== rtl/mcib_pkg.sv =====
// Shared constants, types and helper functions for the motion-compensated
// interpolation blend. No dependencies; every other file imports this package.
package mcib_pkg;

  // Port and datapath widths.
  localparam int unsigned PIX_PORT_W     = 16;
  localparam int unsigned PIXEL_BITS_DEF = 16;
  localparam int unsigned MASK_W         = 9;
  localparam int unsigned TW_W           = 9;
  localparam int unsigned DP_W           = 32;
  localparam int unsigned FRAC_W         = 8;
  localparam int unsigned T_W            = DP_W - FRAC_W;
  localparam int unsigned CFG_IDX_W      = 8;
  localparam int unsigned CFG_DATA_W     = 16;

  // Rounding constant and register reset values.
  localparam logic [DP_W-1:0] RND_HALF     = DP_W'(256);
  localparam logic [TW_W-1:0] TW_RESET     = TW_W'(128);
  localparam logic            MEDIAN_RESET = 1'b0;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TIME_WEIGHT = CFG_IDX_W'(0),
    REG_MEDIAN_MODE = CFG_IDX_W'(1)
  } cfg_reg_t;

  // Payload between the front stages and the rounding stages.
  typedef struct packed {
    logic              median;
    logic [MASK_W-1:0] mf;
    logic [MASK_W-1:0] mb;
    logic [DP_W-1:0]   fw;
    logic [DP_W-1:0]   bw;
    logic [DP_W-1:0]   sa;
    logic [DP_W-1:0]   sb;
  } front_t;

  // The two mask-blended terms ahead of the time mix.
  typedef struct packed {
    logic [T_W-1:0] t1;
    logic [T_W-1:0] t2;
  } t_pair_t;

  // Median of three, with the first two arguments as the ordered pair.
  function automatic logic [PIX_PORT_W-1:0] med3(input logic [PIX_PORT_W-1:0] x,
                                                 input logic [PIX_PORT_W-1:0] y,
                                                 input logic [PIX_PORT_W-1:0] z);
    logic [PIX_PORT_W-1:0] lo;
    logic [PIX_PORT_W-1:0] hi;
    logic [PIX_PORT_W-1:0] c;
    lo = (x < y) ? x : y;
    hi = (x < y) ? y : x;
    c  = (z < hi) ? z : hi;
    return (c > lo) ? c : lo;
  endfunction

endpackage

// ===== rtl/mcib_if.sv =====
// Valid/ready channel interfaces for input items, result items and config writes.
// Depends on mcib_pkg for field widths.
interface mcib_in_if import mcib_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [PIX_PORT_W-1:0] fwd_pixel;
  logic [PIX_PORT_W-1:0] bwd_pixel;
  logic [PIX_PORT_W-1:0] fwd_origin_pixel;
  logic [PIX_PORT_W-1:0] bwd_origin_pixel;
  logic [PIX_PORT_W-1:0] fwd_hop_pixel;
  logic [PIX_PORT_W-1:0] bwd_hop_pixel;
  logic [MASK_W-1:0]     fwd_mask;
  logic [MASK_W-1:0]     bwd_mask;

  modport source (output valid, fwd_pixel, bwd_pixel, fwd_origin_pixel, bwd_origin_pixel,
                  fwd_hop_pixel, bwd_hop_pixel, fwd_mask, bwd_mask, input ready);
  modport sink (input valid, fwd_pixel, bwd_pixel, fwd_origin_pixel, bwd_origin_pixel,
                fwd_hop_pixel, bwd_hop_pixel, fwd_mask, bwd_mask, output ready);
endinterface

interface mcib_out_if import mcib_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [PIX_PORT_W-1:0] out_pixel;

  modport source (output valid, out_pixel, input ready);
  modport sink (input valid, out_pixel, output ready);
endinterface

interface mcib_cfg_if import mcib_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] wdata;

  modport source (output valid, index, wdata, input ready);
  modport sink (input valid, index, wdata, output ready);
endinterface

// ===== rtl/mcib_front.sv =====
// Stages 1 and 2: mask products and median selection, then the weighted sums.
// Depends on mcib_pkg.
module mcib_front import mcib_pkg::*; #(
  parameter int unsigned PIXEL_BITS = PIXEL_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  median_mode,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [PIXEL_BITS-1:0] fwd_pixel,
  input  logic [PIXEL_BITS-1:0] bwd_pixel,
  input  logic [PIXEL_BITS-1:0] fwd_origin_pixel,
  input  logic [PIXEL_BITS-1:0] bwd_origin_pixel,
  input  logic [PIXEL_BITS-1:0] fwd_hop_pixel,
  input  logic [PIXEL_BITS-1:0] bwd_hop_pixel,
  input  logic [MASK_W-1:0]     fwd_mask,
  input  logic [MASK_W-1:0]     bwd_mask,
  output logic                  out_valid,
  input  logic                  out_ready,
  output front_t                out_data
);

  localparam int unsigned PM_W = PIXEL_BITS + MASK_W;

  logic                  v1_r;
  logic                  rdy1;
  logic                  median1_r;
  logic [MASK_W-1:0]     mf1_r;
  logic [MASK_W-1:0]     mb1_r;
  logic [PIXEL_BITS-1:0] f1_r;
  logic [PIXEL_BITS-1:0] b1_r;
  logic [PM_W-1:0]       fm1_r;
  logic [PM_W-1:0]       bm1_r;
  logic [PM_W-1:0]       xa1_r;
  logic [PM_W-1:0]       xb1_r;

  logic                  v2_r;
  logic                  rdy2;
  front_t                s2_r;
  front_t                s2_nxt;

  logic [PIXEL_BITS-1:0] med_b;
  logic [PIXEL_BITS-1:0] med_f;
  logic [PIXEL_BITS-1:0] opa;
  logic [PIXEL_BITS-1:0] opb;
  logic [MASK_W-1:0]     opma;
  logic [MASK_W-1:0]     opmb;
  logic [DP_W-1:0]       fw;
  logic [DP_W-1:0]       bw;

  // Stage handshake: a stage takes a new item when empty or when it drains.
  assign rdy2     = !v2_r || out_ready;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;

  // Stage 1 operands: the median replaces the origin pixel in median mode.
  always_comb begin
    med_b = PIXEL_BITS'(med3(PIX_PORT_W'(bwd_pixel), PIX_PORT_W'(fwd_pixel),
                             PIX_PORT_W'(bwd_hop_pixel)));
    med_f = PIXEL_BITS'(med3(PIX_PORT_W'(bwd_pixel), PIX_PORT_W'(fwd_pixel),
                             PIX_PORT_W'(fwd_hop_pixel)));
    opa   = median_mode ? med_b : fwd_origin_pixel;
    opb   = median_mode ? med_f : bwd_origin_pixel;
    opma  = median_mode ? fwd_mask : bwd_mask;
    opmb  = median_mode ? bwd_mask : fwd_mask;
  end

  // Stage 1 registers: four narrow products.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (rdy1) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      median1_r <= median_mode;
      mf1_r     <= fwd_mask;
      mb1_r     <= bwd_mask;
      f1_r      <= fwd_pixel;
      b1_r      <= bwd_pixel;
      fm1_r     <= PM_W'(fwd_pixel) * PM_W'(fwd_mask);
      bm1_r     <= PM_W'(bwd_pixel) * PM_W'(bwd_mask);
      xa1_r     <= PM_W'(opa) * PM_W'(opma);
      xb1_r     <= PM_W'(opb) * PM_W'(opmb);
    end
  end

  // Stage 2: pixel times (256 - mask) modulo 2^32, then the paired sums.
  always_comb begin
    fw            = (DP_W'(f1_r) << FRAC_W) - DP_W'(fm1_r);
    bw            = (DP_W'(b1_r) << FRAC_W) - DP_W'(bm1_r);
    s2_nxt.median = median1_r;
    s2_nxt.mf     = mf1_r;
    s2_nxt.mb     = mb1_r;
    s2_nxt.fw     = fw;
    s2_nxt.bw     = bw;
    s2_nxt.sa     = (median1_r ? fw : bw) + DP_W'(xa1_r);
    s2_nxt.sb     = (median1_r ? bw : fw) + DP_W'(xb1_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (rdy2) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2) begin
      s2_r <= s2_nxt;
    end
  end

  assign out_valid = v2_r;
  assign out_data  = s2_r;

  // An accepted item lands in stage 1, and a stalled stage 1 keeps its item.
  a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> v1_r)
    else $error("accepted item missing from stage 1");
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    v1_r && !rdy2 |=> v1_r && $stable(fm1_r) && $stable(xa1_r))
    else $error("stage 1 item lost under stall");

endmodule

// ===== rtl/mcib_round.sv =====
// Stages 3 and 4: exact mask-times-inner product with rounding, then the two terms.
// Depends on mcib_pkg.
module mcib_round import mcib_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  front_t  in_data,
  output logic    out_valid,
  input  logic    out_ready,
  output t_pair_t out_data
);

  localparam int unsigned PROD_W = DP_W + MASK_W;

  logic            v3_r;
  logic            rdy3;
  logic            median3_r;
  logic [DP_W-1:0] fw3_r;
  logic [DP_W-1:0] bw3_r;
  logic [DP_W-1:0] sa3_r;
  logic [DP_W-1:0] sb3_r;
  logic [DP_W-1:0] pa3_r;
  logic [DP_W-1:0] pb3_r;

  logic            v4_r;
  logic            rdy4;
  t_pair_t         t4_r;
  t_pair_t         t4_nxt;

  logic [PROD_W-1:0] pa_sum;
  logic [PROD_W-1:0] pb_sum;
  logic [DP_W-1:0]   sum1;
  logic [DP_W-1:0]   sum2;

  assign rdy4     = !v4_r || out_ready;
  assign rdy3     = !v3_r || rdy4;
  assign in_ready = rdy3;

  // Stage 3: mask times inner term, exact to 41 bits, rounded and shifted.
  always_comb begin
    pa_sum = PROD_W'(in_data.mf) * PROD_W'(in_data.sa) + PROD_W'(RND_HALF);
    pb_sum = PROD_W'(in_data.mb) * PROD_W'(in_data.sb) + PROD_W'(RND_HALF);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (rdy3) begin
      v3_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3) begin
      median3_r <= in_data.median;
      fw3_r     <= in_data.fw;
      bw3_r     <= in_data.bw;
      sa3_r     <= in_data.sa;
      sb3_r     <= in_data.sb;
      pa3_r     <= pa_sum[DP_W+FRAC_W-1:FRAC_W];
      pb3_r     <= pb_sum[DP_W+FRAC_W-1:FRAC_W];
    end
  end

  // Stage 4: the median sums are already complete; occlusion adds the rounded product.
  always_comb begin
    sum1      = median3_r ? (sa3_r + RND_HALF) : (fw3_r + pa3_r + RND_HALF);
    sum2      = median3_r ? (sb3_r + RND_HALF) : (bw3_r + pb3_r + RND_HALF);
    t4_nxt.t1 = sum1[DP_W-1:FRAC_W];
    t4_nxt.t2 = sum2[DP_W-1:FRAC_W];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (rdy4) begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy4) begin
      t4_r <= t4_nxt;
    end
  end

  assign out_valid = v4_r;
  assign out_data  = t4_r;

  // A stalled stage 4 keeps its terms for the time mix.
  a_terms_hold: assert property (@(posedge clk) disable iff (!rst_n)
    v4_r && !out_ready |=> v4_r && $stable(t4_r))
    else $error("stage 4 terms changed under stall");

endmodule

// ===== rtl/mcib_mix.sv =====
// Stages 5 and 6: time-weighted mix of the two terms and the final minus-one.
// Depends on mcib_pkg; stage 6 is the result register.
module mcib_mix import mcib_pkg::*; #(
  parameter int unsigned PIXEL_BITS = PIXEL_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [TW_W-1:0]       time_weight,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  t_pair_t               in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [PIX_PORT_W-1:0] out_pixel
);

  localparam int unsigned TM_W = T_W + TW_W;

  logic                  v5_r;
  logic                  rdy5;
  logic [DP_W-1:0]       p1_r;
  logic [DP_W-1:0]       p2_r;
  logic [TM_W-1:0]       m1;
  logic [TM_W-1:0]       m2;

  logic                  v6_r;
  logic                  rdy6;
  logic [PIXEL_BITS-1:0] pix_r;
  logic [PIXEL_BITS-1:0] pix_nxt;
  logic [DP_W-1:0]       mix;

  assign rdy6     = !v6_r || out_ready;
  assign rdy5     = !v5_r || rdy6;
  assign in_ready = rdy5;

  // Stage 5: t1*(256-time) is formed as t1*256 - t1*time, modulo 2^32.
  always_comb begin
    m1 = TM_W'(in_data.t1) * TM_W'(time_weight);
    m2 = TM_W'(in_data.t2) * TM_W'(time_weight);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else if (rdy5) begin
      v5_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy5) begin
      p1_r <= (DP_W'(in_data.t1) << FRAC_W) - m1[DP_W-1:0];
      p2_r <= m2[DP_W-1:0];
    end
  end

  // Stage 6: sum, drop the fraction, subtract one with wrap in pixel width.
  always_comb begin
    mix     = p1_r + p2_r;
    pix_nxt = mix[PIXEL_BITS+FRAC_W-1:FRAC_W] - PIXEL_BITS'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v6_r <= 1'b0;
    end else if (rdy6) begin
      v6_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy6) begin
      pix_r <= pix_nxt;
    end
  end

  assign out_valid = v6_r;
  assign out_pixel = PIX_PORT_W'(pix_r);

  // A stage 5 item that moves on becomes a result in the next cycle.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    v5_r && rdy6 |=> v6_r)
    else $error("stage 5 item did not reach the result register");

endmodule

// ===== rtl/motion_comp_interp_blend_unit.sv =====
// Motion-compensated interpolation blend, top level: config registers and six stages.
// Each accepted item passes through the stage registers in order to the result register;
// throughput 1 item per cycle while the output is not stalled, every stage is pipelined.
// A stalled output holds each stage that is full; empty stages still take items.
// Reset (rst_n low, synchronous) empties the pipeline, sets time_weight to 128 and
// median_mode to 0. Depends on mcib_pkg, mcib_if, mcib_front, mcib_round, mcib_mix.
module motion_comp_interp_blend_unit import mcib_pkg::*; #(
  parameter int unsigned PIXEL_BITS = PIXEL_BITS_DEF
) (
  input logic      clk,
  input logic      rst_n,
  mcib_in_if.sink  in_ch,
  mcib_out_if.source out_ch,
  mcib_cfg_if.sink cfg_ch
);

  logic [TW_W-1:0] time_weight_r;
  logic            median_mode_r;
  logic            cfg_wr;

  logic            f_valid;
  logic            f_ready;
  front_t          f_data;
  logic            r_valid;
  logic            r_ready;
  t_pair_t         r_data;

  // Configuration writes are always taken; unknown indexes are dropped.
  assign cfg_ch.ready = 1'b1;
  assign cfg_wr       = cfg_ch.valid && cfg_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_weight_r <= TW_RESET;
      median_mode_r <= MEDIAN_RESET;
    end else if (cfg_wr) begin
      case (cfg_reg_t'(cfg_ch.index))
        REG_TIME_WEIGHT: time_weight_r <= cfg_ch.wdata[TW_W-1:0];
        REG_MEDIAN_MODE: median_mode_r <= cfg_ch.wdata[0];
        default: ;
      endcase
    end
  end

  // Products, median selection and weighted sums.
  mcib_front #(
    .PIXEL_BITS(PIXEL_BITS)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .median_mode      (median_mode_r),
    .in_valid         (in_ch.valid),
    .in_ready         (in_ch.ready),
    .fwd_pixel        (in_ch.fwd_pixel[PIXEL_BITS-1:0]),
    .bwd_pixel        (in_ch.bwd_pixel[PIXEL_BITS-1:0]),
    .fwd_origin_pixel (in_ch.fwd_origin_pixel[PIXEL_BITS-1:0]),
    .bwd_origin_pixel (in_ch.bwd_origin_pixel[PIXEL_BITS-1:0]),
    .fwd_hop_pixel    (in_ch.fwd_hop_pixel[PIXEL_BITS-1:0]),
    .bwd_hop_pixel    (in_ch.bwd_hop_pixel[PIXEL_BITS-1:0]),
    .fwd_mask         (in_ch.fwd_mask),
    .bwd_mask         (in_ch.bwd_mask),
    .out_valid        (f_valid),
    .out_ready        (f_ready),
    .out_data         (f_data)
  );

  // Rounded occlusion products and the two blended terms.
  mcib_round u_round (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_data   (f_data),
    .out_valid (r_valid),
    .out_ready (r_ready),
    .out_data  (r_data)
  );

  // Time mix and result register.
  mcib_mix #(
    .PIXEL_BITS(PIXEL_BITS)
  ) u_mix (
    .clk         (clk),
    .rst_n       (rst_n),
    .time_weight (time_weight_r),
    .in_valid    (r_valid),
    .in_ready    (r_ready),
    .in_data     (r_data),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .out_pixel   (out_ch.out_pixel)
  );

  // A write to the mode register takes the low data bit.
  a_mode_write: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr && (cfg_ch.index == REG_MEDIAN_MODE) |=> median_mode_r == $past(cfg_ch.wdata[0]))
    else $error("median mode register not updated by its write");

endmodule

// ===== bench/motion_comp_interp_blend_unit_tb.sv =====
// Self-checking testbench for motion_comp_interp_blend_unit: directed corner pixels, then
// random pixels over both blend modes and many time weights, with random stalls.
// Depends on mcib_pkg, the mcib_if channel interfaces and the block's RTL.
module motion_comp_interp_blend_unit_tb;
  import mcib_pkg::*;

  localparam int unsigned CYCLE_LIMIT     = 200000;
  localparam int unsigned SETTLE_CYCLES   = 10;
  localparam int unsigned PHASE_ITEMS     = 125;
  localparam int unsigned PHASE_COUNT     = 6;
  localparam int unsigned PRESSURE_AT     = 300;
  localparam int unsigned PRESSURE_CYCLES = 80;
  localparam int unsigned IDLE_PCT        = 13;
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = CFG_IDX_W'(5);
  localparam logic [DP_W-1:0]      Q8_ONE       = DP_W'(256);

  // One pixel item as the input channel carries it.
  typedef struct packed {
    logic [PIX_PORT_W-1:0] fwd;
    logic [PIX_PORT_W-1:0] bwd;
    logic [PIX_PORT_W-1:0] fwd_org;
    logic [PIX_PORT_W-1:0] bwd_org;
    logic [PIX_PORT_W-1:0] fwd_hop;
    logic [PIX_PORT_W-1:0] bwd_hop;
    logic [MASK_W-1:0]     fwd_mask;
    logic [MASK_W-1:0]     bwd_mask;
  } pix_item_t;

  // Mirrors the two registers and keeps the blended pixels still owed by the block.
  class blend_scoreboard;
    logic [TW_W-1:0]       time_weight;
    logic                  median_mode;
    logic [PIX_PORT_W-1:0] expected_pixels[$];
    int unsigned           mismatches;
    int unsigned           checked;
    int unsigned           occl_items;
    int unsigned           median_items;

    function new();
      time_weight  = TW_W'(128);
      median_mode  = 1'b0;
      mismatches   = 0;
      checked      = 0;
      occl_items   = 0;
      median_items = 0;
    endfunction

    // Writes to unmapped indexes are dropped; data is cut to the register width.
    function void apply_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_TIME_WEIGHT: time_weight = data[TW_W-1:0];
        REG_MEDIAN_MODE: median_mode = data[0];
        default: ;
      endcase
    endfunction

    function logic [DP_W-1:0] median3(logic [DP_W-1:0] a, logic [DP_W-1:0] b,
                                      logic [DP_W-1:0] c);
      logic [DP_W-1:0] lo;
      logic [DP_W-1:0] hi;
      lo = (a < b) ? a : b;
      hi = (a < b) ? b : a;
      if (c <= lo) return lo;
      if (c >= hi) return hi;
      return c;
    endfunction

    // Computes the output pixel in a 32-bit datapath; only the mask times the inner
    // occlusion term is kept exact in 64 bits. Masks or time above 256 wrap on purpose.
    function logic [PIX_PORT_W-1:0] blend_pixel(pix_item_t it);
      logic [DP_W-1:0] f, b, mf, mb, imf, imb, tw, itw;
      logic [DP_W-1:0] fw, bw, inner_a, inner_b, pa, pb, t1, t2, mix;
      logic [63:0]     wide_a, wide_b;
      f   = DP_W'(it.fwd);
      b   = DP_W'(it.bwd);
      mf  = DP_W'(it.fwd_mask);
      mb  = DP_W'(it.bwd_mask);
      imf = Q8_ONE - mf;
      imb = Q8_ONE - mb;
      tw  = DP_W'(time_weight);
      itw = Q8_ONE - tw;
      if (!median_mode) begin
        fw      = f * imf;
        bw      = b * imb;
        inner_a = bw + mb * DP_W'(it.fwd_org);
        inner_b = fw + mf * DP_W'(it.bwd_org);
        wide_a  = 64'(mf) * 64'(inner_a) + 64'(Q8_ONE);
        wide_b  = 64'(mb) * 64'(inner_b) + 64'(Q8_ONE);
        pa      = wide_a[DP_W+7:8];
        pb      = wide_b[DP_W+7:8];
        t1      = (fw + pa + Q8_ONE) >> 8;
        t2      = (bw + pb + Q8_ONE) >> 8;
      end else begin
        t1 = (median3(b, f, DP_W'(it.bwd_hop)) * mf + f * imf + Q8_ONE) >> 8;
        t2 = (median3(b, f, DP_W'(it.fwd_hop)) * mb + b * imb + Q8_ONE) >> 8;
      end
      mix = ((t1 * itw + t2 * tw) >> 8) - DP_W'(1);
      return mix[PIX_PORT_W-1:0];
    endfunction

    function void note_input(pix_item_t it);
      expected_pixels.push_back(blend_pixel(it));
      if (median_mode) median_items++;
      else occl_items++;
    endfunction

    function void check_pixel(logic [PIX_PORT_W-1:0] got);
      logic [PIX_PORT_W-1:0] want;
      if (expected_pixels.size() == 0) begin
        $error("out_pixel: unexpected item, expected none, actual %h", got);
        mismatches++;
        return;
      end
      want = expected_pixels.pop_front();
      checked++;
      if (got !== want) begin
        $error("out_pixel: expected %h, actual %h", want, got);
        mismatches++;
      end
    endfunction

    function int unsigned outstanding();
      return expected_pixels.size();
    endfunction
  endclass

  logic            clk;
  logic            rst_n;
  bit              no_idle;
  int unsigned     cycle_count = 0;
  blend_scoreboard sb;

  mcib_in_if  in_ch();
  mcib_out_if out_ch();
  mcib_cfg_if cfg_ch();

  motion_comp_interp_blend_unit u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Pixel draws lean on the range ends; the rest are uniform.
  function automatic logic [PIX_PORT_W-1:0] random_pixel();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return PIX_PORT_W'($urandom_range(0, 65535));
    endcase
  endfunction

  // Masks are mostly in range, with the ends and the wrapping values above 256 mixed in.
  function automatic logic [MASK_W-1:0] random_mask();
    case ($urandom_range(0, 9))
      0: return MASK_W'(0);
      1: return MASK_W'(256);
      2: return MASK_W'($urandom_range(257, 511));
      default: return MASK_W'($urandom_range(0, 256));
    endcase
  endfunction

  function automatic pix_item_t random_item();
    pix_item_t it;
    it.fwd      = random_pixel();
    it.bwd      = random_pixel();
    it.fwd_org  = random_pixel();
    it.bwd_org  = random_pixel();
    it.fwd_hop  = random_pixel();
    it.bwd_hop  = random_pixel();
    it.fwd_mask = random_mask();
    it.bwd_mask = random_mask();
    return it;
  endfunction

  // Offers one item, sometimes after a one-cycle gap, and returns at the edge it is taken.
  task automatic send_item(pix_item_t it);
    int unsigned gap;
    gap = 0;
    if (!no_idle && $urandom_range(0, 99) < IDLE_PCT) gap = 1;
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid            <= 1'b1;
    in_ch.fwd_pixel        <= it.fwd;
    in_ch.bwd_pixel        <= it.bwd;
    in_ch.fwd_origin_pixel <= it.fwd_org;
    in_ch.bwd_origin_pixel <= it.bwd_org;
    in_ch.fwd_hop_pixel    <= it.fwd_hop;
    in_ch.bwd_hop_pixel    <= it.bwd_hop;
    in_ch.fwd_mask         <= it.fwd_mask;
    in_ch.bwd_mask         <= it.bwd_mask;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_input(it);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.wdata <= data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    sb.apply_write(idx, data);
    cfg_ch.valid <= 1'b0;
  endtask

  // Stops offering items and waits until every owed pixel has come out.
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Result side: checks each item taken and drives ready with random stalls and
  // one long hold that backs the pipeline up into the input.
  initial begin : result_sink
    int unsigned hold_left;
    bit          pressure_done;
    hold_left     = 0;
    pressure_done = 1'b0;
    out_ch.ready  = 1'b0;
    forever begin
      @(posedge clk);
      if (out_ch.valid && out_ch.ready) sb.check_pixel(out_ch.out_pixel);
      if (!pressure_done && sb.checked >= PRESSURE_AT) begin
        hold_left     = PRESSURE_CYCLES;
        pressure_done = 1'b1;
      end
      if (!rst_n) begin
        out_ch.ready <= 1'b0;
      end else if (hold_left != 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        out_ch.ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  initial begin : stimulus
    int unsigned           phase;
    logic [CFG_DATA_W-1:0] tw_data;
    sb                     = new();
    no_idle                = 1'b0;
    rst_n                  = 1'b0;
    in_ch.valid            = 1'b0;
    in_ch.fwd_pixel        = '0;
    in_ch.bwd_pixel        = '0;
    in_ch.fwd_origin_pixel = '0;
    in_ch.bwd_origin_pixel = '0;
    in_ch.fwd_hop_pixel    = '0;
    in_ch.bwd_hop_pixel    = '0;
    in_ch.fwd_mask         = '0;
    in_ch.bwd_mask         = '0;
    cfg_ch.valid           = 1'b0;
    cfg_ch.index           = '0;
    cfg_ch.wdata           = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Occlusion blend at the reset settings: zeros, full scale, full and wrapping masks.
    send_item('{16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 9'd0, 9'd0});
    send_item('{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 9'd0, 9'd0});
    send_item('{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 9'd256, 9'd256});
    send_item('{16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF, 16'h1234, 16'hABCD, 9'd128, 9'd128});
    send_item('{16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 16'h5555, 16'hAAAA, 9'd256, 9'd256});
    send_item('{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 9'd511, 9'd511});
    send_item('{16'h8000, 16'h7FFF, 16'h00FF, 16'hFF00, 16'h0000, 16'h0000, 9'd257, 9'd0});

    // Median blend with the time at the backward frame; hop below, between and above.
    settle();
    write_reg(REG_TIME_WEIGHT, CFG_DATA_W'(0));
    write_reg(REG_MEDIAN_MODE, CFG_DATA_W'(1));
    send_item('{16'h4000, 16'hC000, 16'hFFFF, 16'hFFFF, 16'h0100, 16'h0100, 9'd128, 9'd128});
    send_item('{16'h4000, 16'hC000, 16'h0000, 16'h0000, 16'h8000, 16'h9000, 9'd256, 9'd256});
    send_item('{16'h4000, 16'hC000, 16'h0000, 16'h0000, 16'hF000, 16'hFFFF, 9'd200, 9'd56});
    send_item('{16'h7777, 16'h7777, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 9'd256, 9'd256});
    // Wrapping mask drives the blend to zero, so the minus one wraps to all ones.
    send_item('{16'h0001, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 9'd257, 9'd0});
    send_item('{16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 16'h0000, 9'd511, 9'd511});

    // Time at the forward frame, then the unmapped index and masked writes.
    settle();
    write_reg(REG_TIME_WEIGHT, CFG_DATA_W'(256));
    write_reg(REG_UNMAPPED, 16'hFFFF);
    send_item('{16'h1000, 16'hF000, 16'h0000, 16'h0000, 16'h2000, 16'hE000, 9'd64, 9'd192});
    send_item('{16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 9'd0, 9'd256});
    settle();
    write_reg(REG_TIME_WEIGHT, 16'hFFFF);
    write_reg(REG_MEDIAN_MODE, 16'hFFFE);
    send_item('{16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 9'd0, 9'd0});
    send_item('{16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 9'd300, 9'd100});
    send_item('{16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 16'h0000, 9'd256, 9'd0});

    // Random phases; each sets its own time weight and mode, one runs with no idling.
    for (phase = 0; phase < PHASE_COUNT; phase++) begin
      settle();
      case (phase)
        0: tw_data = CFG_DATA_W'($urandom_range(0, 256));
        2: tw_data = CFG_DATA_W'(0);
        3: tw_data = CFG_DATA_W'(256);
        4: tw_data = {7'h7F, 9'($urandom_range(257, 511))};
        default: tw_data = CFG_DATA_W'($urandom_range(0, 511));
      endcase
      write_reg(REG_TIME_WEIGHT, tw_data);
      write_reg(REG_MEDIAN_MODE, CFG_DATA_W'(phase % 2));
      no_idle = (phase == 1);
      repeat (PHASE_ITEMS) send_item(random_item());
    end
    no_idle = 1'b0;
    settle();

    $display("Blend run: %0d occlusion and %0d median items, %0d pixels checked.",
             sb.occl_items, sb.median_items, sb.checked);
    $display("Time weights covered 0, 256 and wrapping values; %0d mismatches.",
             sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
